/* src/cse_pkg.sv */
package cse_pkg;

  // Gap shrink factor 1.247 taken as the exact ratio 1000/1247
  localparam int unsigned GAP_NUM = 1000;
  localparam int unsigned GAP_DEN = 1247;

  // gap*1000/1247 as a multiply by ceil(2^28*1000/1247) and a 28-bit shift;
  // exact for every gap below 2^20
  localparam int unsigned GAP_RECIP_SH = 28;
  localparam int unsigned GAP_RECIP    = 215265001;

  // Input mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Result kind codes
  localparam logic KIND_SORT_DONE = 1'b0;
  localparam logic KIND_READ_DATA = 1'b1;

endpackage

/* src/cse_ram.sv */
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/cse_gapdiv.sv */
module cse_gapdiv #(
  parameter int GW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [GW-1:0] gap_in,
  output logic          done,
  output logic [GW-1:0] quot
);

  localparam int SH = int'(cse_pkg::GAP_RECIP_SH);
  localparam int PW = GW + SH;

  logic          done_r, done_nxt;
  logic [GW-1:0] quot_r, quot_nxt;
  logic [PW-1:0] prod;

  // Scale the gap by the fixed-point reciprocal; the shift drops the fraction
  assign prod     = PW'(gap_in) * PW'(cse_pkg::GAP_RECIP);
  assign quot_nxt = prod[PW-1:SH];
  assign done_nxt = start;

  // Register the quotient; done follows start in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* src/comb_sort_engine_top.sv */
// Load beats are taken one per cycle while idle; a read result goes out after ST_RD_ADDR
// and ST_RD_DATA. A sort starts on the load marked last: a comparison runs ST_LOOP,
// ST_CMP_ADDR, ST_CMP and, with a swap, ST_SWAP2; a pass adds ST_PASS, ST_DIV (gap update)
// while the gap exceeds one, and the loop exit. No beat is taken during a read or a sort;
// the result register lets a new beat be taken while the previous result still waits.
// Reset is synchronous, active low: control and counters clear, store contents do not.
module comb_sort_engine_top #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  input  logic [9:0]         in_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [31:0] out_element,
  output logic               out_is_final,
  output logic [31:0]        out_swap_count,
  output logic [31:0]        out_compare_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 10) ? CW : 10;
  localparam logic [DATA_WIDTH-1:0] SIGN_FLIP = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_RD_ADDR  = 10'b0000000010,
    ST_RD_DATA  = 10'b0000000100,
    ST_PASS     = 10'b0000001000,
    ST_DIV      = 10'b0000010000,
    ST_LOOP     = 10'b0000100000,
    ST_CMP_ADDR = 10'b0001000000,
    ST_CMP      = 10'b0010000000,
    ST_SWAP2    = 10'b0100000000,
    ST_DONE     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         gap_r, gap_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic                  swapped_r, swapped_nxt;
  logic                  sorted_r, sorted_nxt;
  logic [31:0]           swaps_r, swaps_nxt;
  logic [31:0]           compares_r, compares_nxt;
  logic [AW-1:0]         addr_a_r, addr_a_nxt;
  logic [AW-1:0]         addr_b_r, addr_b_nxt;
  logic [DATA_WIDTH-1:0] hold_r, hold_nxt;
  logic                  rd_hit_r, rd_hit_nxt;
  logic                  rd_final_r, rd_final_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [31:0]           out_element_r, out_element_nxt;
  logic                  out_is_final_r, out_is_final_nxt;
  logic [31:0]           out_swap_count_r, out_swap_count_nxt;
  logic [31:0]           out_compare_count_r, out_compare_count_nxt;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;

  logic                  div_start;
  logic                  div_done;
  logic [CW-1:0]         div_quot;

  logic                  in_acc;
  logic                  slot_free;
  logic [CW-1:0]         load_base;
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] load_word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [63:0]           rd_ext;
  logic [IW:0]           idx_w;
  logic [IW:0]           cnt_w;
  logic [CW-1:0]         div_gap;

  cse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (addr_a_r),
    .raddr_b (addr_b_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  cse_gapdiv #(
    .GW (CW)
  ) u_gapdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .gap_in (gap_r),
    .done   (div_done),
    .quot   (div_quot)
  );

  // Handshake terms
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Store words with the sign bit flipped so unsigned order is signed order
  assign val_ext   = 64'(in_value);
  assign load_word = val_ext[DATA_WIDTH-1:0] ^ SIGN_FLIP;
  assign rd_word   = rdata_a ^ SIGN_FLIP;
  assign rd_ext    = 64'($signed(rd_word));
  assign load_base = sorted_r ? '0 : count_r;

  // Read index checks against the element count
  assign idx_w = (IW+1)'(in_index);
  assign cnt_w = (IW+1)'(count_r);

  // Shrunk gap, never below one
  assign div_gap = (div_quot == '0) ? CW'(1) : div_quot;

  always_comb begin
    state_nxt             = state_r;
    count_nxt             = count_r;
    gap_nxt               = gap_r;
    i_nxt                 = i_r;
    swapped_nxt           = swapped_r;
    sorted_nxt            = sorted_r;
    swaps_nxt             = swaps_r;
    compares_nxt          = compares_r;
    addr_a_nxt            = addr_a_r;
    addr_b_nxt            = addr_b_r;
    hold_nxt              = hold_r;
    rd_hit_nxt            = rd_hit_r;
    rd_final_nxt          = rd_final_r;
    out_valid_nxt         = out_valid_r && out_stall;
    out_kind_nxt          = out_kind_r;
    out_element_nxt       = out_element_r;
    out_is_final_nxt      = out_is_final_r;
    out_swap_count_nxt    = out_swap_count_r;
    out_compare_count_nxt = out_compare_count_r;
    we                    = 1'b0;
    waddr                 = addr_a_r;
    wdata                 = rdata_b;
    div_start             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == cse_pkg::MODE_LOAD) begin
          // store the beat, drop it when the store is full
          count_nxt = load_base;
          if (load_base < CW'(DEPTH)) begin
            we        = 1'b1;
            waddr     = AW'(load_base);
            wdata     = load_word;
            count_nxt = load_base + CW'(1);
          end
          sorted_nxt = 1'b0;
          if (in_last) begin
            sorted_nxt   = 1'b1;
            gap_nxt      = count_nxt;
            swaps_nxt    = '0;
            compares_nxt = '0;
            swapped_nxt  = 1'b1;
            state_nxt    = ST_PASS;
          end
        end else if (in_acc) begin
          addr_a_nxt   = AW'(in_index);
          rd_hit_nxt   = (idx_w < cnt_w);
          rd_final_nxt = ((idx_w + (IW+1)'(1)) == cnt_w);
          state_nxt    = ST_RD_ADDR;
        end
      end

      ST_RD_ADDR: begin
        state_nxt = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        // hand the read data over once the result register is free
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_kind_nxt          = cse_pkg::KIND_READ_DATA;
          out_element_nxt       = rd_hit_r ? rd_ext[31:0] : '0;
          out_is_final_nxt      = rd_hit_r && rd_final_r;
          out_swap_count_nxt    = '0;
          out_compare_count_nxt = '0;
          state_nxt             = ST_IDLE;
        end
      end

      ST_PASS: begin
        // finish once a gap-one pass made no swap
        if (!swapped_r && gap_r <= CW'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          swapped_nxt = 1'b0;
          if (gap_r > CW'(1)) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            gap_nxt   = CW'(1);
            i_nxt     = CW'(1);
            state_nxt = ST_LOOP;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          gap_nxt   = div_gap;
          i_nxt     = div_gap;
          state_nxt = ST_LOOP;
        end
      end

      ST_LOOP: begin
        if (i_r >= count_r) begin
          state_nxt = ST_PASS;
        end else begin
          addr_a_nxt = AW'(i_r);
          addr_b_nxt = AW'(i_r - gap_r);
          state_nxt  = ST_CMP_ADDR;
        end
      end

      ST_CMP_ADDR: begin
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        // compare the pair, write the first half of a swap
        compares_nxt = (compares_r == '1) ? compares_r : compares_r + 32'd1;
        if (rdata_a < rdata_b) begin
          we          = 1'b1;
          waddr       = addr_a_r;
          wdata       = rdata_b;
          hold_nxt    = rdata_a;
          swaps_nxt   = (swaps_r == '1) ? swaps_r : swaps_r + 32'd1;
          swapped_nxt = 1'b1;
          state_nxt   = ST_SWAP2;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_LOOP;
        end
      end

      ST_SWAP2: begin
        we        = 1'b1;
        waddr     = addr_b_r;
        wdata     = hold_r;
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_LOOP;
      end

      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_kind_nxt          = cse_pkg::KIND_SORT_DONE;
          out_element_nxt       = '0;
          out_is_final_nxt      = 1'b0;
          out_swap_count_nxt    = swaps_r;
          out_compare_count_nxt = compares_r;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      gap_r       <= '0;
      i_r         <= '0;
      swapped_r   <= 1'b0;
      sorted_r    <= 1'b0;
      swaps_r     <= '0;
      compares_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      gap_r       <= gap_nxt;
      i_r         <= i_nxt;
      swapped_r   <= swapped_nxt;
      sorted_r    <= sorted_nxt;
      swaps_r     <= swaps_nxt;
      compares_r  <= compares_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_a_r            <= addr_a_nxt;
    addr_b_r            <= addr_b_nxt;
    hold_r              <= hold_nxt;
    rd_hit_r            <= rd_hit_nxt;
    rd_final_r          <= rd_final_nxt;
    out_kind_r          <= out_kind_nxt;
    out_element_r       <= out_element_nxt;
    out_is_final_r      <= out_is_final_nxt;
    out_swap_count_r    <= out_swap_count_nxt;
    out_compare_count_r <= out_compare_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_element       = out_element_r;
  assign out_is_final      = out_is_final_r;
  assign out_swap_count    = out_swap_count_r;
  assign out_compare_count = out_compare_count_r;

endmodule
